// File: sv/sckx_pkg.sv
package sckx_pkg;

  typedef logic [31:0]       sckx_word_t;
  typedef logic [15:0][31:0] sckx_block_t;
  typedef logic [4:0][31:0]  sckx_hash_t;

  // sizes
  localparam int unsigned KeyWords   = 8;
  localparam int unsigned KeyIdxW    = 3;
  localparam logic [4:0]  BlockBytes = 5'd16;

  // sha-1 initial hash value, h0 in element 0
  localparam sckx_hash_t Sha1Iv = {32'hC3D2_E1F0, 32'h1032_5476, 32'h98BA_DCFE,
                                   32'hEFCD_AB89, 32'h6745_2301};

  // padding block of a single 64-byte message
  localparam sckx_block_t PadBlock = {32'd512, {14{32'd0}}, 32'h8000_0000};

  // round constants and phase limits
  localparam sckx_word_t K0 = 32'h5A82_7999;
  localparam sckx_word_t K1 = 32'h6ED9_EBA1;
  localparam sckx_word_t K2 = 32'h8F1B_BCDC;
  localparam sckx_word_t K3 = 32'hCA62_C1D6;

  localparam logic [6:0] RoundPhase1 = 7'd20;
  localparam logic [6:0] RoundPhase2 = 7'd40;
  localparam logic [6:0] RoundPhase3 = 7'd60;
  localparam logic [6:0] RoundLast   = 7'd79;

  // byte order swap of one word
  function automatic sckx_word_t bswap32(input sckx_word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // rotate left by one
  function automatic sckx_word_t rotl1(input sckx_word_t x);
    return {x[30:0], x[31]};
  endfunction

endpackage

// File: sv/sckx_in_if.sv
interface sckx_in_if;
  logic        valid;
  logic        ready;
  logic        restart;
  logic [63:0] plain_low;
  logic [63:0] plain_high;
  logic [4:0]  byte_count;

  modport source (output valid, output restart, output plain_low, output plain_high,
                  output byte_count, input ready);
  modport sink (input valid, input restart, input plain_low, input plain_high,
                input byte_count, output ready);
endinterface

// File: sv/sckx_out_if.sv
interface sckx_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_low;
  logic [63:0] cipher_high;

  modport source (output valid, output cipher_low, output cipher_high, input ready);
  modport sink (input valid, input cipher_low, input cipher_high, output ready);
endinterface

// File: sv/sckx_sha1_core.sv
module sckx_sha1_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  sckx_pkg::sckx_block_t msg_i,
  output logic                  done_o,
  output logic [63:0]           ks_low_o,
  output logic [63:0]           ks_high_o
);

  localparam logic [1:0] CS_IDLE = 2'd0;
  localparam logic [1:0] CS_RND  = 2'd1;
  localparam logic [1:0] CS_ADD  = 2'd2;

  logic [1:0]            state_q;
  logic [6:0]            rnd_q;
  logic                  blk_q;
  logic                  done_q;
  sckx_pkg::sckx_hash_t  h_q;
  sckx_pkg::sckx_hash_t  st_q;
  sckx_pkg::sckx_block_t win_q;

  sckx_pkg::sckx_word_t  f_w;
  sckx_pkg::sckx_word_t  k_w;
  sckx_pkg::sckx_word_t  tmp_w;
  sckx_pkg::sckx_word_t  w_new;
  sckx_pkg::sckx_hash_t  h_sum;

  // round function and constant by phase
  always_comb begin
    if (rnd_q < sckx_pkg::RoundPhase1) begin
      f_w = (st_q[1] & st_q[2]) | (~st_q[1] & st_q[3]);
      k_w = sckx_pkg::K0;
    end else if (rnd_q < sckx_pkg::RoundPhase2) begin
      f_w = st_q[1] ^ st_q[2] ^ st_q[3];
      k_w = sckx_pkg::K1;
    end else if (rnd_q < sckx_pkg::RoundPhase3) begin
      f_w = (st_q[1] & st_q[2]) | (st_q[1] & st_q[3]) | (st_q[2] & st_q[3]);
      k_w = sckx_pkg::K2;
    end else begin
      f_w = st_q[1] ^ st_q[2] ^ st_q[3];
      k_w = sckx_pkg::K3;
    end
  end

  // shared round adder and schedule word
  assign tmp_w = {st_q[0][26:0], st_q[0][31:27]} + f_w + st_q[4] + k_w + win_q[0];
  assign w_new = sckx_pkg::rotl1(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0]);

  // chaining value update
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      h_sum[i] = h_q[i] + st_q[i];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      rnd_q   <= '0;
      blk_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == CS_ADD) && blk_q;
      case (state_q)
        CS_IDLE: begin
          if (start_i) begin
            state_q <= CS_RND;
            rnd_q   <= '0;
            blk_q   <= 1'b0;
          end
        end
        CS_RND: begin
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == sckx_pkg::RoundLast) begin
            state_q <= CS_ADD;
          end
        end
        CS_ADD: begin
          if (!blk_q) begin
            blk_q   <= 1'b1;
            rnd_q   <= '0;
            state_q <= CS_RND;
          end else begin
            state_q <= CS_IDLE;
          end
        end
        default: state_q <= CS_IDLE;
      endcase
    end
  end

  // working variables, schedule window and digest
  always_ff @(posedge clk_i) begin
    case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          h_q   <= sckx_pkg::Sha1Iv;
          st_q  <= sckx_pkg::Sha1Iv;
          win_q <= msg_i;
        end
      end
      CS_RND: begin
        st_q  <= {st_q[3], st_q[2], {st_q[1][1:0], st_q[1][31:2]}, st_q[0], tmp_w};
        win_q <= {w_new, win_q[15:1]};
      end
      CS_ADD: begin
        h_q <= h_sum;
        if (!blk_q) begin
          st_q  <= h_sum;
          win_q <= sckx_pkg::PadBlock;
        end
      end
      default: ;
    endcase
  end

  // digest bytes 0..15, byte 0 in the low bits
  assign ks_low_o  = {sckx_pkg::bswap32(h_q[1]), sckx_pkg::bswap32(h_q[0])};
  assign ks_high_o = {sckx_pkg::bswap32(h_q[3]), sckx_pkg::bswap32(h_q[2])};
  assign done_o    = done_q;

endmodule

// File: sv/sha1_counter_keystream_xor_core.sv
// channel   | dir | signals
// ----------+-----+------------------------------------------------------
// data_in_i | in  | valid/ready, restart, plain_low, plain_high, byte_count
// data_out_o| out | valid/ready, cipher_low, cipher_high
// apb       | in  | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// between input transfer and result an item runs two sha-1 compressions of
// 80 rounds each on one shared round adder
// a zero byte count skips the hash and goes from transfer straight to the done state
// reset clears the key registers and the counter to zero at once
// a new item is taken once the previous one is finished, even while its result
// still waits in the output register for the sink
module sha1_counter_keystream_xor_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  sckx_in_if.sink      data_in_i,
  sckx_out_if.source   data_out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_HASH  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                              state_q;
  logic [sckx_pkg::KeyWords-1:0][63:0]     key_q;
  logic [sckx_pkg::KeyWords-1:0][63:0]     ctr_q;
  logic [511:0]                            ctr_flat;
  logic [sckx_pkg::KeyIdxW-1:0]            inc_idx_q;
  logic                                    inc_act_q;
  logic [63:0]                             inc_sum;
  logic [63:0]                             plain_low_q;
  logic [63:0]                             plain_high_q;
  logic [4:0]                              count_q;
  logic [4:0]                              count_sat;
  logic                                    out_valid_q;
  logic [63:0]                             cipher_low_q;
  logic [63:0]                             cipher_high_q;
  logic                                    in_xfer;
  logic                                    cfg_wr;
  logic                                    out_load;
  logic                                    core_start;
  logic                                    core_done;
  logic [63:0]                             ks_low;
  logic [63:0]                             ks_high;
  logic [127:0]                            byte_mask;
  logic [127:0]                            cipher_next;
  sckx_pkg::sckx_block_t                   msg;

  assign in_xfer    = data_in_i.valid && data_in_i.ready;
  assign cfg_wr     = psel && penable && pwrite;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || data_out_o.ready);
  assign core_start = (state_q == ST_START);
  assign count_sat  = (data_in_i.byte_count > sckx_pkg::BlockBytes) ?
                      sckx_pkg::BlockBytes : data_in_i.byte_count;

  // register access
  assign pready = 1'b1;
  assign prdata = key_q[paddr[5:3]];

  // key registers and counter
  assign inc_sum = ctr_q[inc_idx_q] + 64'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      ctr_q     <= '0;
      inc_idx_q <= '0;
      inc_act_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        key_q[paddr[5:3]] <= pwdata;
      end
      // one counter word per cycle while the carry ripples
      if (in_xfer && data_in_i.restart) begin
        ctr_q <= key_q;
      end else if (inc_act_q) begin
        ctr_q[inc_idx_q] <= inc_sum;
      end
      if (core_start) begin
        inc_act_q <= 1'b1;
        inc_idx_q <= '0;
      end else if (inc_act_q) begin
        inc_idx_q <= inc_idx_q + 1'b1;
        if ((inc_sum != 64'd0) || (inc_idx_q == sckx_pkg::KeyIdxW'(sckx_pkg::KeyWords - 1))) begin
          inc_act_q <= 1'b0;
        end
      end
    end
  end

  // counter bytes as big-endian message words
  assign ctr_flat = ctr_q;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      msg[i] = sckx_pkg::bswap32(ctr_flat[32*i +: 32]);
    end
  end

  sckx_sha1_core u_sha1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (core_start),
    .msg_i     (msg),
    .done_o    (core_done),
    .ks_low_o  (ks_low),
    .ks_high_o (ks_high)
  );

  // item sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            state_q <= (count_sat == 5'd0) ? ST_DONE : ST_START;
          end
        end
        ST_START: state_q <= ST_HASH;
        ST_HASH: begin
          if (core_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      plain_low_q  <= data_in_i.plain_low;
      plain_high_q <= data_in_i.plain_high;
      count_q      <= count_sat;
    end
  end

  // valid byte lanes
  always_comb begin
    for (int b = 0; b < 16; b++) begin
      byte_mask[8*b +: 8] = (5'(b) < count_q) ? 8'hFF : 8'h00;
    end
  end

  assign cipher_next = ({plain_high_q, plain_low_q} ^ {ks_high, ks_low}) & byte_mask;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (data_out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cipher_low_q  <= cipher_next[63:0];
      cipher_high_q <= cipher_next[127:64];
    end
  end

  assign data_in_i.ready        = (state_q == ST_IDLE);
  assign data_out_o.valid       = out_valid_q;
  assign data_out_o.cipher_low  = cipher_low_q;
  assign data_out_o.cipher_high = cipher_high_q;

endmodule

// File: sv/sckx_checker.sv
module sckx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] cipher_low_i,
  input logic [63:0] cipher_high_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cipher_low_i)
      && $stable(cipher_high_i))
    else $error("stalled result changed");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  // ready drops only on a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i))
    else $error("input ready dropped without transfer");

  // a new result comes only at the end of an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result without an item in flight");

endmodule

bind sha1_counter_keystream_xor_core sckx_checker u_sckx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (data_in_i.valid),
  .in_ready_i    (data_in_i.ready),
  .out_valid_i   (data_out_o.valid),
  .out_ready_i   (data_out_o.ready),
  .cipher_low_i  (data_out_o.cipher_low),
  .cipher_high_i (data_out_o.cipher_high)
);
